FILE: rtl/pcx_rle_pkg.sv
// shared types and constants of the pcx run-length palette decoder
package pcx_rle_pkg;

    // input operation codes, carried in s_tuser
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_DATA    = 2'd2;

    // run header marker and run length field of a compressed byte
    localparam logic [1:0] RUN_MARK   = 2'b11;
    localparam int         RUN_BITS   = 6;
    localparam logic [7:0] BYTE_MAX   = 8'hFF;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_RUN   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [7:0]            index;
        logic [23:0]           color;
        logic [RUN_BITS-1:0]   run;
    } cmd_t;

endpackage

FILE: rtl/pcx_rle_palette_decoder.sv
// top level of the pcx run-length decoder with palette lookup
//
//  channel   direction  transfer
//  s_*       in         one command item: palette write, sprite start or image byte
//  m_*       out        one rgba pixel
//  cfg_*     in         pixel total register write
//
// the front takes one item per cycle while the four-entry command queue has room.
// the back handles a palette write or start while idle; a run takes it to the emit
// state, which emits the run's pixels from the registered palette read, stalls on
// m_tready and returns to idle on the run's last pixel or at the pixel limit.
// rst_n clears parser state, queue, pixel count and the pixel total; the palette
// store is not cleared. a stalled m_tready holds the back and, once the queue fills,
// s_tready.
module pcx_rle_palette_decoder
    import pcx_rle_pkg::*;
#(
    parameter int PALETTE_ENTRIES  = 256,
    parameter int PIXEL_COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, palette_index, red_in, green_in, blue_in
    input  logic        s_tlast,   // final_byte
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red, green, blue, alpha
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser,   // image_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data   // pixel_total
);

    logic        total_reg_en;
    logic [23:0] pixel_total_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    cmd_t        push_cmd;
    cmd_t        head_cmd;

    // configuration register
    assign cfg_ready    = 1'b1;
    assign total_reg_en = cfg_valid && cfg_ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_total_reg <= '0;
        end
        else if (total_reg_en)
        begin
            pixel_total_reg <= cfg_data;
        end
    end

    pcx_rle_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    pcx_rle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    pcx_rle_back #(
        .PALETTE_ENTRIES  (PALETTE_ENTRIES),
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_total (pixel_total_reg),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

FILE: rtl/pcx_rle_front.sv
// front part: accepts input items, parses run headers, issues commands
module pcx_rle_front
    import pcx_rle_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, palette_index, red_in, green_in, blue_in
    input  logic        s_tlast,   // final_byte
    input  logic [1:0]  s_tuser,   // operation
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic                awaiting_reg;
    logic                awaiting_next;
    logic [RUN_BITS-1:0] pending_reg;
    logic [RUN_BITS-1:0] pending_next;
    logic                accept;
    logic [7:0]          data_byte;
    logic [7:0]          pal_index;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign data_byte = s_tdata[7:0];
    assign pal_index = s_tdata[15:8];

    // classify the item and build the command for the back part
    always_comb
    begin
        awaiting_next = awaiting_reg;
        pending_next  = pending_reg;
        q_push        = 1'b0;
        q_cmd.kind    = CMD_RUN;
        q_cmd.index   = data_byte;
        q_cmd.color   = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
        q_cmd.run     = RUN_BITS'(1);
        if (accept)
        begin
            unique case (s_tuser)
                OP_PALETTE:
                begin
                    q_cmd.kind  = CMD_WRITE;
                    q_cmd.index = pal_index;
                    q_push      = ({1'b0, pal_index} < 9'(PALETTE_ENTRIES));
                end
                OP_START:
                begin
                    q_cmd.kind    = CMD_START;
                    q_push        = 1'b1;
                    awaiting_next = 1'b0;
                    pending_next  = '0;
                end
                OP_DATA:
                begin
                    if (awaiting_reg)
                    begin
                        // color byte of a run, a zero run yields nothing
                        awaiting_next = 1'b0;
                        pending_next  = '0;
                        q_cmd.run     = pending_reg;
                        q_push        = (pending_reg != '0);
                    end
                    else if (data_byte[7:6] == RUN_MARK)
                    begin
                        // run header, dropped when it is the final byte
                        if (!s_tlast)
                        begin
                            awaiting_next = 1'b1;
                            pending_next  = data_byte[RUN_BITS-1:0];
                        end
                    end
                    else
                    begin
                        q_push = 1'b1;
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            pending_reg  <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

FILE: rtl/pcx_rle_queue.sv
// short command queue between the front and back parts
module pcx_rle_queue
    import pcx_rle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head_cmd
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   fill_reg;
    logic [QPTR_BITS:0]   fill_next;

    assign full     = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // fill level follows push and pop
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/pcx_rle_back.sv
// back part: palette store, pixel count and pixel output register
module pcx_rle_back
    import pcx_rle_pkg::*;
#(
    parameter int PALETTE_ENTRIES  = 256,
    parameter int PIXEL_COUNT_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] pixel_total,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red, green, blue, alpha
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser    // image_done
);

    localparam int ADDR_BITS = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW        = (PIXEL_COUNT_BITS > 24) ? PIXEL_COUNT_BITS : 24;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [23:0]                 palette_mem [PALETTE_ENTRIES];
    logic [23:0]                 rd_data_reg;
    logic [7:0]                  index_reg;
    logic [RUN_BITS-1:0]         remain_reg;
    logic [RUN_BITS-1:0]         remain_next;
    logic [PIXEL_COUNT_BITS-1:0] count_reg;
    logic [PIXEL_COUNT_BITS-1:0] count_next;
    logic [PIXEL_COUNT_BITS-1:0] count_inc;
    logic [PIXEL_COUNT_BITS-1:0] limit;
    logic [CW-1:0]               total_ext;
    logic [CW-1:0]               mask_ext;
    logic                        in_range;
    logic                        out_free;
    logic                        emit;
    logic                        pix_last;
    logic                        pix_done;
    logic [31:0]                 pixel;
    logic                        m_valid_reg;
    logic [31:0]                 m_data_reg;
    logic                        m_last_reg;
    logic                        m_done_reg;

    // pixel limit, saturated to what the counter holds
    assign total_ext = CW'(pixel_total);
    assign mask_ext  = CW'({PIXEL_COUNT_BITS{1'b1}});
    assign limit     = (total_ext > mask_ext) ? {PIXEL_COUNT_BITS{1'b1}}
                                              : total_ext[PIXEL_COUNT_BITS-1:0];

    // color of the current run
    assign in_range = ({1'b0, index_reg} < 9'(PALETTE_ENTRIES));
    always_comb
    begin
        pixel = '0;
        if (index_reg != '0)
        begin
            pixel[31:24] = BYTE_MAX;
            if (in_range)
            begin
                pixel[7:0]   = rd_data_reg[23:16];
                pixel[15:8]  = rd_data_reg[15:8];
                pixel[23:16] = rd_data_reg[7:0];
            end
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_free  = !m_valid_reg || m_tready;
    assign count_inc = count_reg + 1'b1;
    assign pix_done  = (count_inc == limit);
    assign pix_last  = (remain_reg == RUN_BITS'(1)) || pix_done;
    assign emit      = (state_reg == S_EMIT) && (count_reg < limit) && out_free;

    // command sequencing
    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_cmd.kind == CMD_START)
                    begin
                        count_next = '0;
                    end
                    else if (q_cmd.kind == CMD_RUN)
                    begin
                        remain_next = q_cmd.run;
                        state_next  = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (count_reg >= limit)
                begin
                    state_next = S_IDLE;
                end
                else if (emit)
                begin
                    remain_next = remain_reg - 1'b1;
                    count_next  = count_inc;
                    if (pix_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            remain_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_data_reg <= pixel;
            m_last_reg <= pix_last;
            m_done_reg <= pix_done;
        end
    end

    // palette store, one write per palette write command and one read per run command
    always_ff @(posedge clk)
    begin
        if (q_pop && (q_cmd.kind == CMD_WRITE))
        begin
            palette_mem[q_cmd.index[ADDR_BITS-1:0]] <= q_cmd.color;
        end
        if (q_pop && (q_cmd.kind == CMD_RUN))
        begin
            rd_data_reg <= palette_mem[q_cmd.index[ADDR_BITS-1:0]];
            index_reg   <= q_cmd.index;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_done_reg;

endmodule
